// ----- hw/rtl/deque_with_key_search_remove_assert.svh -----
// assertion macros shared by the deque rtl
`ifndef DEQUE_WITH_KEY_SEARCH_REMOVE_ASSERT_SVH
`define DEQUE_WITH_KEY_SEARCH_REMOVE_ASSERT_SVH
`ifndef ASSERT_OFF
`define DQKS_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("deque assertion failed");
`define DQKS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("deque assertion failed");
`else
`define DQKS_ASSERT_IMPL(label, ante, cons)
`define DQKS_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ----- hw/rtl/dqks_pkg.sv -----
// shared types and codes for the deque with key search
package dqks_pkg;

    typedef enum logic [2:0] {
        OP_PUSH_FRONT = 3'd0,
        OP_PUSH_BACK  = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_POP_BACK   = 3'd3,
        OP_SEARCH     = 3'd4,
        OP_REMOVE_KEY = 3'd5,
        OP_READ_FRONT = 3'd6
    } op_t;

    typedef enum logic [1:0] {
        ST_DONE = 2'd0,
        ST_MISS = 2'd1,
        ST_FULL = 2'd2
    } status_t;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_EXEC = 1'b1
    } fsm_t;

    // broadcast to every cell of the row
    typedef struct packed {
        logic en;
        logic push_front;
        logic push_back;
        logic pop_front;
        logic remove_key;
    } cell_ctrl_t;

    localparam int OUT_DATA_W  = 32;
    localparam int OUT_MATCH_W = 4;
    localparam int OUT_COUNT_W = 5;

endpackage

// ----- hw/rtl/dqks_cell.sv -----
// one storage cell of the deque row: holds one entry and shifts with its neighbors
module dqks_cell #(
    parameter int INDEX      = 0,
    parameter int DATA_WIDTH = 32,
    parameter int CW         = 5,
    parameter int IW         = 4
) (
    input  logic                   aclk,
    input  dqks_pkg::cell_ctrl_t   ctrl,
    input  logic [DATA_WIDTH-1:0]  key,
    input  logic [CW-1:0]          count,
    input  logic [DATA_WIDTH-1:0]  left_in,
    input  logic [DATA_WIDTH-1:0]  right_in,
    output logic [DATA_WIDTH-1:0]  entry_out,
    input  logic                   found_in,
    output logic                   found_out,
    input  logic [IW-1:0]          idx_in,
    output logic [IW-1:0]          idx_out,
    input  logic [DATA_WIDTH-1:0]  tail_in,
    output logic [DATA_WIDTH-1:0]  tail_out
);
    import dqks_pkg::*;

    localparam bit IS_HEAD = (INDEX == 0);

    logic [DATA_WIDTH-1:0] entry_reg;
    logic [DATA_WIDTH-1:0] entry_next;
    logic                  occupied;
    logic                  hit;
    logic                  first_hit;
    logic                  is_tail;

    assign occupied  = CW'(INDEX) < count;
    assign hit       = occupied && (entry_reg == key);
    assign first_hit = hit && !found_in;
    assign is_tail   = occupied && (CW'(INDEX + 1) == count);

    // first-match and tail value ripple toward the back of the row
    assign found_out = found_in | hit;
    assign idx_out   = idx_in | (first_hit ? IW'(INDEX) : '0);
    assign tail_out  = tail_in | (is_tail ? entry_reg : '0);
    assign entry_out = entry_reg;

    always_comb begin
        entry_next = entry_reg;
        priority if (!ctrl.en) begin
            entry_next = entry_reg;
        end else if (ctrl.push_front) begin
            entry_next = IS_HEAD ? key : left_in;
        end else if (ctrl.push_back) begin
            if (CW'(INDEX) == count) begin
                entry_next = key;
            end
        end else if (ctrl.pop_front) begin
            entry_next = right_in;
        end else if (ctrl.remove_key) begin
            // the matching cell and all behind it close the gap
            if (found_out) begin
                entry_next = right_in;
            end
        end
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

endmodule

// ----- hw/rtl/deque_with_key_search_remove.sv -----
// Bounded deque of signed entries with key search and key removal.
// Input channel s_axis: one transaction per operation; opcode on s_axis_tuser,
// value (element to insert or key) on s_axis_tdata. Output channel m_axis:
// exactly one result transaction per operation, in order; status on
// m_axis_tuser, data, match index and entry count on m_axis_tdata.
// Entries live in a row of DEPTH cells. Each cell compares its entry with the
// key and shifts toward its neighbor, so any operation finishes in one pass.
// The input transaction is captured into the operation and key registers;
// the update of the cell row then loads the output register.
// A new operation is not taken before the previous one has updated the cell
// row; s_axis_tready is high only in the capture state.
// The next operation is accepted while a result waits in the output register;
// its update cycle waits until the receiver takes that result, so a stalled
// m_axis holds the result and back-pressures s_axis after one more item.
// Reset (aresetn low, synchronous) empties the deque and drops any pending
// result; entry storage is not cleared and only occupied cells are read.
module deque_with_key_search_remove #(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] value
    input  logic [2:0]  s_axis_tuser,   // [2:0] opcode
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // [31:0] data, [35:32] match_index, [40:36] count
    output logic [1:0]  m_axis_tuser    // [1:0] status
);
    import dqks_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);
    localparam int IW = $clog2(DEPTH);

    fsm_t                  state_reg;
    fsm_t                  state_next;
    logic                  s_accept;
    logic                  exec_fire;

    op_t                   op_reg;
    logic [DATA_WIDTH-1:0] key_reg;
    logic [DATA_WIDTH-1:0] key_in;
    logic [CW-1:0]         count_reg;
    logic [CW-1:0]         count_next;

    cell_ctrl_t            ctrl;
    status_t               status_next;
    logic [DATA_WIDTH-1:0] data_sel;
    logic [IW-1:0]         match_next;
    logic                  full;
    logic                  empty;

    logic [DATA_WIDTH-1:0] entry_w [DEPTH];
    logic [DATA_WIDTH-1:0] left_w  [DEPTH];
    logic [DATA_WIDTH-1:0] right_w [DEPTH];
    logic                  found_w [DEPTH+1];
    logic [IW-1:0]         idx_w   [DEPTH+1];
    logic [DATA_WIDTH-1:0] tail_w  [DEPTH+1];

    logic [OUT_DATA_W-1:0]  data_out;
    logic [OUT_MATCH_W-1:0] match_out;
    logic [OUT_COUNT_W-1:0] count_out;

    logic                   m_valid_reg;
    logic                   m_valid_next;
    status_t                status_reg;
    logic [OUT_DATA_W-1:0]  data_reg;
    logic [OUT_MATCH_W-1:0] match_reg;
    logic [OUT_COUNT_W-1:0] count_out_reg;

    // sign-extend or truncate 32-bit value to entry width; zero-extend/truncate outputs
    generate
        if (DATA_WIDTH > 32) begin : g_key_ext
            assign key_in = {{(DATA_WIDTH - 32){s_axis_tdata[31]}}, s_axis_tdata};
        end else begin : g_key_trunc
            assign key_in = s_axis_tdata[DATA_WIDTH-1:0];
        end
        if (DATA_WIDTH >= OUT_DATA_W) begin : g_data_trunc
            assign data_out = data_sel[OUT_DATA_W-1:0];
        end else begin : g_data_ext
            assign data_out = {{(OUT_DATA_W - DATA_WIDTH){1'b0}}, data_sel};
        end
        if (IW >= OUT_MATCH_W) begin : g_match_trunc
            assign match_out = match_next[OUT_MATCH_W-1:0];
        end else begin : g_match_ext
            assign match_out = {{(OUT_MATCH_W - IW){1'b0}}, match_next};
        end
        if (CW >= OUT_COUNT_W) begin : g_count_trunc
            assign count_out = count_next[OUT_COUNT_W-1:0];
        end else begin : g_count_ext
            assign count_out = {{(OUT_COUNT_W - CW){1'b0}}, count_next};
        end
    endgenerate

    // control sequencer
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: if (s_accept) state_next = S_EXEC;
            S_EXEC: if (exec_fire) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_comb begin
        s_axis_tready = (state_reg == S_IDLE);
        exec_fire     = (state_reg == S_EXEC) && (!m_valid_reg || m_axis_tready);
    end

    assign s_accept = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            op_reg  <= op_t'(s_axis_tuser);
            key_reg <= key_in;
        end
    end

    // row of cells
    assign found_w[0] = 1'b0;
    assign idx_w[0]   = '0;
    assign tail_w[0]  = '0;

    generate
        for (genvar i = 0; i < DEPTH; i++) begin : g_cell
            if (i == 0) begin : g_left_edge
                assign left_w[i] = '0;
            end else begin : g_left
                assign left_w[i] = entry_w[i-1];
            end
            if (i == DEPTH - 1) begin : g_right_edge
                assign right_w[i] = '0;
            end else begin : g_right
                assign right_w[i] = entry_w[i+1];
            end

            dqks_cell #(
                .INDEX      (i),
                .DATA_WIDTH (DATA_WIDTH),
                .CW         (CW),
                .IW         (IW)
            ) u_cell (
                .aclk      (aclk),
                .ctrl      (ctrl),
                .key       (key_reg),
                .count     (count_reg),
                .left_in   (left_w[i]),
                .right_in  (right_w[i]),
                .entry_out (entry_w[i]),
                .found_in  (found_w[i]),
                .found_out (found_w[i+1]),
                .idx_in    (idx_w[i]),
                .idx_out   (idx_w[i+1]),
                .tail_in   (tail_w[i]),
                .tail_out  (tail_w[i+1])
            );
        end
    endgenerate

    assign full  = (count_reg == CW'(DEPTH));
    assign empty = (count_reg == '0);

    // operation decode and result
    always_comb begin
        status_next     = ST_DONE;
        data_sel        = '0;
        match_next      = '0;
        count_next      = count_reg;
        ctrl            = '0;
        unique case (op_reg)
            OP_PUSH_FRONT: begin
                if (full) begin
                    status_next = ST_FULL;
                end else begin
                    ctrl.push_front = 1'b1;
                    count_next      = count_reg + CW'(1);
                end
            end
            OP_PUSH_BACK: begin
                if (full) begin
                    status_next = ST_FULL;
                end else begin
                    ctrl.push_back = 1'b1;
                    count_next     = count_reg + CW'(1);
                end
            end
            OP_POP_FRONT: begin
                if (empty) begin
                    status_next = ST_MISS;
                end else begin
                    ctrl.pop_front = 1'b1;
                    data_sel       = entry_w[0];
                    count_next     = count_reg - CW'(1);
                end
            end
            OP_POP_BACK: begin
                if (empty) begin
                    status_next = ST_MISS;
                end else begin
                    data_sel   = tail_w[DEPTH];
                    count_next = count_reg - CW'(1);
                end
            end
            OP_SEARCH: begin
                if (found_w[DEPTH]) begin
                    match_next = idx_w[DEPTH];
                end else begin
                    status_next = ST_MISS;
                end
            end
            OP_REMOVE_KEY: begin
                if (found_w[DEPTH]) begin
                    ctrl.remove_key = 1'b1;
                    match_next      = idx_w[DEPTH];
                    count_next      = count_reg - CW'(1);
                end else begin
                    status_next = ST_MISS;
                end
            end
            OP_READ_FRONT: begin
                if (empty) begin
                    status_next = ST_MISS;
                end else begin
                    data_sel = entry_w[0];
                end
            end
            default: begin
                // unused opcode: no operation
                status_next = ST_DONE;
            end
        endcase
        ctrl.en = exec_fire;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else if (exec_fire) begin
            count_reg <= count_next;
        end
    end

    // output register
    always_comb begin
        m_valid_next = m_valid_reg;
        priority if (exec_fire) begin
            m_valid_next = 1'b1;
        end else if (m_axis_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (exec_fire) begin
            status_reg    <= status_next;
            data_reg      <= data_out;
            match_reg     <= match_out;
            count_out_reg <= count_out;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tuser  = status_reg;
    assign m_axis_tdata  = {7'b0, count_out_reg, match_reg, data_reg};

    `include "deque_with_key_search_remove_assert.svh"

    `DQKS_ASSERT_IMPL(a_count_bound, 1'b1, count_reg <= CW'(DEPTH))
    `DQKS_ASSERT_NEXT(a_fire_gives_result, exec_fire, m_valid_reg)
    `DQKS_ASSERT_NEXT(a_full_push_holds, exec_fire && full && (op_reg == OP_PUSH_FRONT || op_reg == OP_PUSH_BACK), $stable(count_reg))
    `DQKS_ASSERT_NEXT(a_pop_back_count, exec_fire && !empty && op_reg == OP_POP_BACK, count_reg == $past(count_reg) - CW'(1))
    `DQKS_ASSERT_IMPL(a_no_exec_without_room, exec_fire, !m_valid_reg || m_axis_tready)

endmodule
